// ===== design/bsws_pkg.sv =====
// ----------------------------------------------------------------------------
// bsws_pkg: shared types and constants for the bounded stack with search
// Operation and status codes, payload structs, controller/datapath bundles.
// ----------------------------------------------------------------------------
package bsws_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 8;              // fill level / capacity field width
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(128);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TOP  = 2'd2,
    OP_FIND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOMATCH  = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_RDATA,
    SEL_SCAN
  } out_sel_t;

  typedef struct packed {
    op_t                      mode;
    logic signed [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    stat_t                    status;
    logic [CNT_W-1:0]         match_count;
    logic [CNT_W-1:0]         fill_level;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic     capture;
    logic     push_wr;
    logic     rd_top;
    logic     dec;
    logic     scan_start;
    logic     scan_step;
    logic     out_load;
    out_sel_t out_sel;
    stat_t    out_code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_done;
  } sts_t;

endpackage

// ===== design/bsws_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsws_ctrl: operation sequencer
// Runs the handshakes and steps the datapath through push, pop/top and scan.
// ----------------------------------------------------------------------------
module bsws_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsws_pkg::op_t      in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  input  bsws_pkg::sts_t     sts,
  output bsws_pkg::cmd_t     cmd
);

  bsws_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsws_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == bsws_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign fire      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_sel  = bsws_pkg::SEL_DIRECT;
    cmd.out_code = bsws_pkg::ST_OK;

    unique case (state_r)
      bsws_pkg::S_IDLE: begin
        if (fire) begin
          cmd.capture = 1'b1;
          unique case (in_mode)
            bsws_pkg::OP_PUSH: begin
              cmd.out_load = 1'b1;
              if (sts.full) begin
                cmd.out_code = bsws_pkg::ST_OVERFLOW;
              end else begin
                cmd.push_wr = 1'b1;
              end
            end
            bsws_pkg::OP_POP, bsws_pkg::OP_TOP: begin
              if (sts.empty) begin
                cmd.out_load = 1'b1;
                cmd.out_code = bsws_pkg::ST_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
                cmd.dec    = (in_mode == bsws_pkg::OP_POP);
                state_nxt  = bsws_pkg::S_READ;
              end
            end
            bsws_pkg::OP_FIND: begin
              if (sts.empty) begin
                cmd.out_load = 1'b1;
                cmd.out_code = bsws_pkg::ST_EMPTY;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = bsws_pkg::S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      bsws_pkg::S_READ: begin
        cmd.out_load = 1'b1;
        cmd.out_sel  = bsws_pkg::SEL_RDATA;
        state_nxt    = bsws_pkg::S_IDLE;
      end
      bsws_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = bsws_pkg::SEL_SCAN;
          state_nxt    = bsws_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsws_pkg::S_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;
  end

endmodule

// ===== design/bsws_dp.sv =====
// ----------------------------------------------------------------------------
// bsws_dp: stack datapath
// Entry memory, fill counter, capacity register, scan counter and result reg.
// ----------------------------------------------------------------------------
module bsws_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bsws_pkg::in_t                  in_data,
  input  logic                           cfg_wr,
  input  logic [bsws_pkg::CNT_W-1:0]     cfg_data,
  input  bsws_pkg::cmd_t                 cmd,
  output bsws_pkg::sts_t                 sts,
  output bsws_pkg::out_t                 out_data
);

  logic [bsws_pkg::DATA_W-1:0] mem [bsws_pkg::DEPTH];

  logic [bsws_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bsws_pkg::CNT_W-1:0]  cap_r;
  logic [bsws_pkg::CNT_W-1:0]  eff_cap;
  logic [bsws_pkg::CNT_W-1:0]  scan_idx_r;
  logic [bsws_pkg::CNT_W-1:0]  mc_r, mc_nxt;
  logic [bsws_pkg::DATA_W-1:0] key_r;
  logic [bsws_pkg::DATA_W-1:0] rdata_r;
  logic [bsws_pkg::ADDR_W-1:0] rd_addr;
  logic [bsws_pkg::CNT_W-1:0]  top_idx;
  bsws_pkg::out_t              out_r, out_nxt;

  assign eff_cap = (cap_r > bsws_pkg::DEPTH_CNT) ? bsws_pkg::DEPTH_CNT : cap_r;
  assign top_idx = count_r - bsws_pkg::CNT_W'(1);

  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r >= eff_cap);
  assign sts.scan_done = (scan_idx_r == count_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.push_wr) count_nxt = count_r + bsws_pkg::CNT_W'(1);
    else if (cmd.dec) count_nxt = top_idx;
  end

  always_comb begin
    rd_addr = scan_idx_r[bsws_pkg::ADDR_W-1:0];
    if (cmd.rd_top) rd_addr = top_idx[bsws_pkg::ADDR_W-1:0];
    else if (cmd.scan_start) rd_addr = '0;
  end

  // compare works on the registered read data (rdata_r), so it lags the read issue
  assign mc_nxt = mc_r + bsws_pkg::CNT_W'(rdata_r == key_r);

  always_comb begin
    out_nxt             = '0;
    out_nxt.fill_level  = count_nxt;
    unique case (cmd.out_sel)
      bsws_pkg::SEL_DIRECT: out_nxt.status = cmd.out_code;
      bsws_pkg::SEL_RDATA: begin
        out_nxt.status   = bsws_pkg::ST_OK;
        out_nxt.data_out = rdata_r;
      end
      bsws_pkg::SEL_SCAN: begin
        out_nxt.status      = (mc_nxt == '0) ? bsws_pkg::ST_NOMATCH : bsws_pkg::ST_OK;
        out_nxt.match_count = mc_nxt;
      end
      default: out_nxt.status = cmd.out_code;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= bsws_pkg::CAP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr) cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) mem[count_r[bsws_pkg::ADDR_W-1:0]] <= in_data.data_in;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) key_r <= in_data.data_in;
    if (cmd.scan_start) begin
      scan_idx_r <= bsws_pkg::CNT_W'(1);
      mc_r       <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + bsws_pkg::CNT_W'(1);
      mc_r       <= mc_nxt;
    end
    if (cmd.out_load) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== design/bounded_stack_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search_unit: bounded LIFO of signed 32-bit words
// Push, pop, top and find-count over a 128-entry stack with set capacity.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer (mode, data_in). in_ready is high only
//           while the unit is idle and the result register is free or being
//           drained in the same cycle.
//   out_* : one result per request (data_out, status, match_count,
//           fill_level), held in an output register until transferred.
//   cfg_* : capacity register write, always ready; write it only while idle.
// Steps from input transfer to out_valid:
//   push, and any request on an empty stack : result registered directly
//   pop, top                                : memory read (S_READ), then result
//   find                                    : scan (S_SCAN) of fill_level entries,
//                                             one entry per cycle on the single
//                                             memory read port
// One request is in flight at a time; the next may be taken in the cycle
// its predecessor's result transfers.
// Reset: stack empty, capacity 128, no result pending. Entries are not
// cleared; only entries below the fill level ever reach a result.
// A stalled receiver holds out_data stable and blocks new requests.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bsws_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bsws_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bsws_pkg::CNT_W-1:0] cfg_data
);

  bsws_pkg::cmd_t cmd;
  bsws_pkg::sts_t sts;

  // Capacity writes never stall.
  assign cfg_ready = 1'b1;

  // Sequencer: handshakes and per-operation steps.
  bsws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage, counters and result register.
  bsws_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== design/bsws_chk.sv =====
// ----------------------------------------------------------------------------
// bsws_chk: port-level checks for the stack unit
// Result holding, single-request flow and result field consistency.
// ----------------------------------------------------------------------------
module bsws_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input bsws_pkg::out_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fill_level <= bsws_pkg::DEPTH_CNT)
    else $error("fill level beyond depth");

  a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.match_count != '0 |->
      out_data.status == bsws_pkg::ST_OK && out_data.data_out == '0)
    else $error("match count with wrong status or data");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bsws_pkg::ST_NOMATCH |->
      out_data.match_count == '0 && out_data.data_out == '0 &&
      out_data.fill_level != '0)
    else $error("no-match result inconsistent");

endmodule

bind bounded_stack_with_search_unit bsws_chk u_bsws_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
